// File: rtl/mersenne_twister_uniform_top_defines.svh
// ----------------------------------------------------------------------------
// mersenne_twister_uniform_top_defines
// Assertion macros shared by the generator's checker.
// ----------------------------------------------------------------------------
`ifndef MERSENNE_TWISTER_UNIFORM_TOP_DEFINES_SVH
`define MERSENNE_TWISTER_UNIFORM_TOP_DEFINES_SVH

// same-cycle implication, held off during reset
`define MTU_ASSERT_IMP(lbl, ck, rstn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("%m: implication failed");

// next-cycle implication, held off during reset
`define MTU_ASSERT_NXT(lbl, ck, rstn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("%m: next-cycle check failed");

// next-cycle implication, live through reset
`define MTU_ASSERT_NXT_RST(lbl, ck, ante, cons) \
	lbl: assert property (@(posedge ck) (ante) |=> (cons)) \
		else $error("%m: reset check failed");

`endif

// File: rtl/mtu_pkg.sv
// ----------------------------------------------------------------------------
// mtu_pkg
// Constants, types and word functions of the MT19937 uniform generator.
// ----------------------------------------------------------------------------
package mtu_pkg;

	localparam int unsigned ADDR_W = 10;
	localparam int unsigned WORD_W = 32;
	localparam int unsigned N_WORDS = 624;

	typedef logic [ADDR_W-1:0] mtu_addr_t;
	typedef logic [WORD_W-1:0] mtu_word_t;

	localparam mtu_addr_t NUM_WORDS = mtu_addr_t'(N_WORDS);
	localparam mtu_addr_t LAST_WORD = mtu_addr_t'(N_WORDS - 1);
	localparam mtu_addr_t FAR_OFFSET = mtu_addr_t'(397 - 1);

	localparam mtu_word_t TW_MATRIX = 32'h9908b0df;
	localparam mtu_word_t TW_UPPER = 32'h80000000;
	localparam mtu_word_t TW_LOWER = 32'h7fffffff;
	localparam mtu_word_t TEMPER_B = 32'h9d2c5680;
	localparam mtu_word_t TEMPER_C = 32'hefc60000;
	localparam mtu_word_t SEED_MULT = 32'd69069;
	localparam mtu_word_t SEED_RESET = 32'd457;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_SEED  = 5'b00010,
		ST_TWIST = 5'b00100,
		ST_READ  = 5'b01000,
		ST_LOAD  = 5'b10000
	} mtu_state_t;

	typedef struct packed {
		logic      we;
		mtu_addr_t waddr;
		mtu_word_t wdata;
		logic      re_a;
		mtu_addr_t raddr_a;
		logic      re_b;
		mtu_addr_t raddr_b;
	} mtu_mem_req_t;

	function automatic mtu_word_t mtu_twist(input mtu_word_t cur, input mtu_word_t nxt,
		input mtu_word_t far);
		mtu_word_t y;
		mtu_word_t v;
		y = (cur & TW_UPPER) | (nxt & TW_LOWER);
		v = far ^ (y >> 1);
		if (y[0]) begin
			v = v ^ TW_MATRIX;
		end
		return v;
	endfunction

	function automatic mtu_word_t mtu_temper(input mtu_word_t w);
		mtu_word_t y;
		y = w ^ (w >> 11);
		y = y ^ ((y << 7) & TEMPER_B);
		y = y ^ ((y << 15) & TEMPER_C);
		y = y ^ (y >> 18);
		return y;
	endfunction

endpackage

// File: rtl/mersenne_twister_uniform_top.sv
// With unread words in the table, an accepted transaction reads its word, and
// ST_LOAD registers the tempered result once the output is free. Every 624th draw
// first twists the table. A restart reseeds, twists twice and reads before drawing.
// s_tready is high only in ST_IDLE, so a new transaction is accepted only after the last result is loaded.
// Reset: seed = 457, then a seeding sweep and a twist with s_tready low.
// ----------------------------------------------------------------------------
// mersenne_twister_uniform_top
// MT19937 generator giving one tempered 32-bit Q0.32 sample per transaction.
// ----------------------------------------------------------------------------
module mersenne_twister_uniform_top import mtu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        seed_wr_en,
	input  logic [31:0] seed_wr_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [0] restart, [7:1] zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata    // [31:0] fraction
);

	mtu_word_t    seed_q;
	mtu_word_t    rdata_a;
	mtu_word_t    rdata_b;
	mtu_mem_req_t mem_req;
	logic         load;
	logic         out_free;
	logic         m_tvalid_q;
	mtu_word_t    m_tdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= SEED_RESET;
		end else if (seed_wr_en) begin
			seed_q <= seed_wr_data;
		end
	end

	mtu_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.restart  (s_tdata[0]),
		.s_tready (s_tready),
		.seed     (seed_q),
		.rdata_a  (rdata_a),
		.rdata_b  (rdata_b),
		.out_free (out_free),
		.load     (load),
		.mem_req  (mem_req)
	);

	mtu_ram #(.DEPTH(N_WORDS), .WIDTH(WORD_W)) u_ram_a (
		.clk     (clk),
		.wr_en   (mem_req.we),
		.wr_addr (mem_req.waddr),
		.wr_data (mem_req.wdata),
		.rd_en   (mem_req.re_a),
		.rd_addr (mem_req.raddr_a),
		.rd_data (rdata_a)
	);

	mtu_ram #(.DEPTH(N_WORDS), .WIDTH(WORD_W)) u_ram_b (
		.clk     (clk),
		.wr_en   (mem_req.we),
		.wr_addr (mem_req.waddr),
		.wr_data (mem_req.wdata),
		.rd_en   (mem_req.re_b),
		.rd_addr (mem_req.raddr_b),
		.rd_data (rdata_b)
	);

	assign out_free = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			m_tdata_q <= mtu_temper(rdata_a);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;

endmodule

// File: rtl/mtu_ram.sv
// ----------------------------------------------------------------------------
// mtu_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module mtu_ram #(
	parameter int unsigned DEPTH = 624,
	parameter int unsigned WIDTH = 32,
	parameter int unsigned AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// File: rtl/mtu_seq.sv
// ----------------------------------------------------------------------------
// mtu_seq
// Sequencer: seeding sweep, in-place twist pipeline and draw addressing.
// ----------------------------------------------------------------------------
module mtu_seq import mtu_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         restart,
	output logic         s_tready,
	input  mtu_word_t    seed,
	input  mtu_word_t    rdata_a,
	input  mtu_word_t    rdata_b,
	input  logic         out_free,
	output logic         load,
	output mtu_mem_req_t mem_req
);

	mtu_state_t state_q;
	mtu_addr_t  cnt_q;
	mtu_addr_t  pos_q;
	mtu_word_t  seed_w_q;
	logic       draw_q;
	logic       extra_q;
	logic       tw_valid_s1;
	mtu_addr_t  tw_idx_s1;
	mtu_word_t  carry_q;
	logic       pos_ok;
	logic [ADDR_W:0] far_sum;
	mtu_addr_t  far_addr;

	assign pos_ok = (pos_q < NUM_WORDS);
	assign s_tready = (state_q == ST_IDLE);
	assign load = (state_q == ST_LOAD) && out_free;

	assign far_sum = {1'b0, cnt_q} + {1'b0, FAR_OFFSET};
	assign far_addr = (far_sum >= {1'b0, NUM_WORDS}) ?
		ADDR_W'(far_sum - {1'b0, NUM_WORDS}) : far_sum[ADDR_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SEED;
			cnt_q <= '0;
			pos_q <= NUM_WORDS;
			seed_w_q <= SEED_RESET;
			draw_q <= 1'b0;
			extra_q <= 1'b0;
			tw_valid_s1 <= 1'b0;
		end else begin
			tw_valid_s1 <= (state_q == ST_TWIST);
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						if (restart) begin
							seed_w_q <= seed;
							cnt_q <= '0;
							pos_q <= NUM_WORDS;
							draw_q <= 1'b1;
							extra_q <= 1'b1;
							state_q <= ST_SEED;
						end else if (!pos_ok) begin
							cnt_q <= '0;
							draw_q <= 1'b1;
							state_q <= ST_TWIST;
						end else begin
							pos_q <= pos_q + 1'b1;
							state_q <= ST_LOAD;
						end
					end
				end
				ST_SEED: begin
					seed_w_q <= seed_w_q * SEED_MULT;
					if (cnt_q == LAST_WORD) begin
						cnt_q <= '0;
						state_q <= ST_TWIST;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_TWIST: begin
					if (cnt_q == NUM_WORDS) begin
						cnt_q <= '0;
						if (extra_q) begin
							extra_q <= 1'b0;
						end else if (draw_q) begin
							draw_q <= 1'b0;
							pos_q <= '0;
							state_q <= ST_READ;
						end else begin
							state_q <= ST_IDLE;
						end
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_READ: begin
					pos_q <= pos_q + 1'b1;
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// carry holds the old value of the word being rewritten
	always_ff @(posedge clk) begin
		tw_idx_s1 <= cnt_q;
		if (tw_valid_s1) begin
			carry_q <= rdata_a;
		end
	end

	always_comb begin
		mem_req.re_a = 1'b0;
		mem_req.raddr_a = pos_q;
		mem_req.re_b = 1'b0;
		mem_req.raddr_b = far_addr;
		mem_req.we = 1'b0;
		mem_req.waddr = tw_idx_s1 - 1'b1;
		mem_req.wdata = mtu_twist(carry_q, rdata_a, rdata_b);
		case (state_q)
			ST_IDLE: begin
				mem_req.re_a = s_tvalid && !restart && pos_ok;
			end
			ST_READ: begin
				mem_req.re_a = 1'b1;
			end
			ST_TWIST: begin
				mem_req.re_a = 1'b1;
				mem_req.raddr_a = (cnt_q == NUM_WORDS) ? '0 : cnt_q;
				mem_req.re_b = 1'b1;
			end
			default: begin
			end
		endcase
		if (state_q == ST_SEED) begin
			mem_req.we = 1'b1;
			mem_req.waddr = cnt_q;
			mem_req.wdata = seed_w_q;
		end else if (tw_valid_s1 && (tw_idx_s1 != '0)) begin
			mem_req.we = 1'b1;
		end
	end

endmodule

// File: rtl/mtu_checker.sv
// ----------------------------------------------------------------------------
// mtu_checker
// Port-level checks of the generator, bound to the top level.
// ----------------------------------------------------------------------------
`include "mersenne_twister_uniform_top_defines.svh"

module mtu_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata
);

	logic s_acc;

	assign s_acc = s_tvalid && s_tready;

	`MTU_ASSERT_NXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
	`MTU_ASSERT_NXT(a_one_in_flight, clk, arst_n, s_acc, !s_tready)
	`MTU_ASSERT_NXT(a_no_instant_result, clk, arst_n, s_acc, !$rose(m_tvalid))
	`MTU_ASSERT_NXT_RST(a_reset_quiet, clk, !arst_n, !s_tready && !m_tvalid)

endmodule

bind mersenne_twister_uniform_top mtu_checker u_mtu_checker (.*);

// File: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Checks the MT19937 uniform generator transaction by transaction. A local
// copy of the word table is seeded, twisted and tempered alongside the block,
// and each output sample is matched to it or a known value. A short directed
// table covers reset state, restarts, seed extremes and the zero seed. Random
// draws with occasional restarts follow, under several idling patterns.
// ----------------------------------------------------------------------------
module tb_top import mtu_pkg::*; ();

	localparam int QUIET_LIMIT = 10000;
	localparam int RANDOM_PHASES = 8;
	localparam int DRAWS_PER_PHASE = 210;

	typedef struct packed {
		logic        load_seed;
		logic [31:0] seed_val;
		logic        restart;
		logic        known;
		logic [31:0] known_fraction;
	} draw_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        seed_wr_en = 1'b0;
	logic [31:0] seed_wr_data = 32'd0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'd0;   // [0] restart, [7:1] zero
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;          // [31:0] fraction

	logic [31:0] gen_words [N_WORDS];
	int unsigned gen_pos;
	logic [31:0] gen_seed;
	logic [31:0] pending_fractions [$];
	int          fail_count = 0;
	int          quiet_cycles = 0;
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;

	// zero seed: the whole table stays zero, so every sample is zero
	draw_row_t directed_rows [20] = '{
		'{1'b0, 32'h0,        1'b0, 1'b0, 32'h0},
		'{1'b0, 32'h0,        1'b0, 1'b0, 32'h0},
		'{1'b0, 32'h0,        1'b0, 1'b0, 32'h0},
		'{1'b0, 32'h0,        1'b0, 1'b0, 32'h0},
		'{1'b0, 32'h0,        1'b1, 1'b0, 32'h0},
		'{1'b0, 32'h0,        1'b0, 1'b0, 32'h0},
		'{1'b1, 32'h0,        1'b0, 1'b0, 32'h0},
		'{1'b0, 32'h0,        1'b1, 1'b1, 32'h0},
		'{1'b0, 32'h0,        1'b0, 1'b1, 32'h0},
		'{1'b0, 32'h0,        1'b0, 1'b1, 32'h0},
		'{1'b0, 32'h0,        1'b1, 1'b1, 32'h0},
		'{1'b1, 32'hffffffff, 1'b1, 1'b0, 32'h0},
		'{1'b0, 32'h0,        1'b0, 1'b0, 32'h0},
		'{1'b1, 32'h00000001, 1'b1, 1'b0, 32'h0},
		'{1'b0, 32'h0,        1'b0, 1'b0, 32'h0},
		'{1'b1, 32'h80000000, 1'b1, 1'b0, 32'h0},
		'{1'b1, 32'h7fffffff, 1'b1, 1'b0, 32'h0},
		'{1'b0, 32'h0,        1'b0, 1'b0, 32'h0},
		'{1'b1, 32'd457,      1'b1, 1'b0, 32'h0},
		'{1'b0, 32'h0,        1'b0, 1'b0, 32'h0}
	};

	mersenne_twister_uniform_top u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.seed_wr_en  (seed_wr_en),
		.seed_wr_data(seed_wr_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata)
	);

	always #6 clk = ~clk;

	function automatic void table_twist();
		logic [31:0] mix;
		logic [31:0] fresh;
		for (int i = 0; i < N_WORDS; i++) begin
			mix = {gen_words[i][31], gen_words[(i + 1) % N_WORDS][30:0]};
			fresh = gen_words[(i + 397) % N_WORDS] ^ {1'b0, mix[31:1]};
			if (mix[0]) begin
				fresh = fresh ^ TW_MATRIX;
			end
			gen_words[i] = fresh;
		end
	endfunction

	function automatic void table_seed();
		gen_words[0] = gen_seed;
		for (int i = 1; i < N_WORDS; i++) begin
			gen_words[i] = gen_words[i - 1] * SEED_MULT;
		end
		table_twist();
		gen_pos = N_WORDS;
	endfunction

	function automatic logic [31:0] next_fraction(input logic restart);
		logic [31:0] w;
		if (restart) begin
			table_seed();
		end
		if (gen_pos >= N_WORDS) begin
			table_twist();
			gen_pos = 0;
		end
		w = gen_words[gen_pos];
		gen_pos = gen_pos + 1;
		w = w ^ {11'd0, w[31:11]};
		w = w ^ ({w[24:0], 7'd0} & TEMPER_B);
		w = w ^ ({w[16:0], 15'd0} & TEMPER_C);
		w = w ^ {18'd0, w[31:18]};
		return w;
	endfunction

	task automatic send_draw(input logic restart, input logic known,
		input logic [31:0] known_fraction);
		logic [31:0] predicted;
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {7'd0, restart};
		do @(posedge clk); while (!s_tready);
		predicted = next_fraction(restart);
		pending_fractions.push_back(known ? known_fraction : predicted);
	endtask

	task automatic drain_results();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_fractions.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_seed(input logic [31:0] value);
		seed_wr_en <= 1'b1;
		seed_wr_data <= value;
		@(negedge clk);
		seed_wr_en <= 1'b0;
		gen_seed = value;
	endtask

	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_fractions.size() == 0) begin
				$error("fraction: unexpected transaction, got %h", m_tdata);
				fail_count = fail_count + 1;
			end else if (m_tdata !== pending_fractions[0]) begin
				$error("fraction: expected %h, got %h", pending_fractions[0], m_tdata);
				fail_count = fail_count + 1;
				void'(pending_fractions.pop_front());
			end else begin
				void'(pending_fractions.pop_front());
			end
		end
	end

	// watchdog on cycles with no transaction on either side
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		gen_seed = SEED_RESET;
		table_seed();
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[r]) begin
			if (directed_rows[r].load_seed) begin
				drain_results();
				write_seed(directed_rows[r].seed_val);
			end
			send_draw(directed_rows[r].restart, directed_rows[r].known,
				directed_rows[r].known_fraction);
		end

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			drain_results();
			write_seed($urandom);
			case (ph % 4)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 67;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 67;
				end
				default: begin
					send_idle_pct = 8;
					recv_stall_pct = 8;
				end
			endcase
			for (int k = 0; k < DRAWS_PER_PHASE; k++) begin
				if ($urandom_range(149) == 0) begin
					drain_results();
				end
				if (k == 0) begin
					send_draw(1'($urandom_range(1)), 1'b0, 32'd0);
				end else begin
					send_draw($urandom_range(119) == 0, 1'b0, 32'd0);
				end
			end
		end

		drain_results();
		repeat (10) @(posedge clk);
		if (fail_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
